// ===== design/gjps_pkg.sv =====
// Shared types, constants and helpers of the grid jump point scan unit.
`default_nettype none
package gjps_pkg;
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = XW + YW;
    localparam int MW = (XW > YW) ? XW : YW;
    localparam int CW = ((MW > 9) ? MW : 9) + 2;

    localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_PRIM_BUDGET = 2'd2;
    localparam logic [1:0] CFG_SUB_BUDGET  = 2'd3;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic [AW-1:0]        maddr_t;

    typedef struct packed {
        coord_t rd_x;
        coord_t rd_y;
        coord_t lim_w;
        coord_t lim_h;
        logic   wr_en;
        maddr_t wr_addr;
        logic   wr_data;
    } map_ctl_t;

    function automatic coord_t dir_step(input logic [1:0] v);
        coord_t r;
        unique case (v)
            2'd0:    r = coord_t'(0);
            2'd1:    r = coord_t'(1);
            default: r = coord_t'(-1);
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== design/gjps_map.sv =====
// Walkability map memory with bounds check; one registered probe per cycle.
`default_nettype none
module gjps_map (
    input  wire logic             aclk,
    input  wire gjps_pkg::map_ctl_t ctl,
    output logic                  rd_open
);
    logic mem [2**gjps_pkg::AW];
    logic bit_reg;
    logic inb_reg;
    gjps_pkg::maddr_t rd_addr;
    logic inb;

    assign rd_addr = {ctl.rd_y[gjps_pkg::YW-1:0], ctl.rd_x[gjps_pkg::XW-1:0]};
    assign inb = (ctl.rd_x >= 0) && (ctl.rd_y >= 0) &&
                 (ctl.rd_x < ctl.lim_w) && (ctl.rd_y < ctl.lim_h);

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[ctl.wr_addr] <= ctl.wr_data;
        end
        bit_reg <= mem[rd_addr];
        inb_reg <= inb;
    end

    assign rd_open = bit_reg & inb_reg;
endmodule
`default_nettype wire

// ===== design/grid_jump_point_scan_unit.sv =====
// Top level of the grid jump point scan unit: sequencer, registers and map.
//
// After reset the map is cleared one cell per cycle, all MAX_WIDTH x
// MAX_HEIGHT cells; s_tready stays low meanwhile. A map write word is taken
// whenever the unit is idle. A query walks cell by cell through one shared
// map probe port with a registered read: each probe is a read state then a
// check state. A straight cell probes its own cell plus four neighbors; a
// diagonal cell probes itself, then runs two straight sub-scans of up to
// (sub_budget + 1) cells each, then probes the two corner cells. One query
// is in flight at a time; the result word is held until taken.
`default_nettype none
module grid_jump_point_scan_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // cell_x, cell_y, walkable, dir_x, dir_y, goal_x, goal_y, emit_on_budget
    input  wire logic [39:0] s_tdata,
    // req_type
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // jump_x, jump_y
    output logic [15:0]      m_tdata,
    // found
    output logic             m_tuser,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_data
);
    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_S_RD, ST_S_CHK, ST_F_RD, ST_F_CHK,
        ST_D_RD, ST_D_CHK, ST_C_RD, ST_C_CHK, ST_OUT
    } state_t;

    state_t state_reg;
    gjps_pkg::maddr_t clr_reg;
    logic [8:0]  gw_reg, gh_reg;
    logic [15:0] pb_reg, sb_reg;
    logic        emit_reg, sub_reg, side_reg;
    gjps_pkg::coord_t gx_reg, gy_reg, px_reg, py_reg, ddx_reg, ddy_reg;
    gjps_pkg::coord_t sx_reg, sy_reg, sdx_reg, sdy_reg;
    logic [16:0] sn_reg, dn_reg;
    logic [1:0]  k_reg;
    logic [3:0]  fb_reg;
    logic        found_reg;
    logic [7:0]  jx_reg, jy_reg;

    gjps_pkg::map_ctl_t ctl;
    logic rd_open;
    gjps_pkg::coord_t in_x, in_y, in_dx, in_dy, pdx, pdy;
    logic [16:0] sn_inc, dn_inc;
    logic        s_end, s_hit, forced;

    assign in_x  = gjps_pkg::CW'(s_tdata[7:0]);
    assign in_y  = gjps_pkg::CW'(s_tdata[15:8]);
    assign in_dx = gjps_pkg::dir_step(s_tdata[18:17]);
    assign in_dy = gjps_pkg::dir_step(s_tdata[20:19]);
    assign pdx   = (sdy_reg != 0) ? gjps_pkg::coord_t'(1) : gjps_pkg::coord_t'(0);
    assign pdy   = (sdx_reg != 0) ? gjps_pkg::coord_t'(1) : gjps_pkg::coord_t'(0);
    assign sn_inc = sn_reg + 17'd1;
    assign dn_inc = dn_reg + 17'd1;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_tdata   = {jy_reg, jx_reg};
    assign m_tuser   = found_reg;

    always_comb begin
        ctl.lim_w = (32'(gw_reg) < gjps_pkg::MAX_WIDTH) ? gjps_pkg::CW'(gw_reg)
                                                       : gjps_pkg::CW'(gjps_pkg::MAX_WIDTH);
        ctl.lim_h = (32'(gh_reg) < gjps_pkg::MAX_HEIGHT) ? gjps_pkg::CW'(gh_reg)
                                                        : gjps_pkg::CW'(gjps_pkg::MAX_HEIGHT);
        if (state_reg == ST_CLEAR) begin
            ctl.wr_en   = 1'b1;
            ctl.wr_addr = clr_reg;
            ctl.wr_data = 1'b0;
        end else begin
            ctl.wr_en   = s_tvalid && s_tready && (s_tuser == gjps_pkg::REQ_WRITE) &&
                          (in_x < gjps_pkg::CW'(gjps_pkg::MAX_WIDTH)) &&
                          (in_y < gjps_pkg::CW'(gjps_pkg::MAX_HEIGHT));
            ctl.wr_addr = {in_y[gjps_pkg::YW-1:0], in_x[gjps_pkg::XW-1:0]};
            ctl.wr_data = s_tdata[16];
        end
        unique case (state_reg)
            ST_S_RD: begin
                ctl.rd_x = sx_reg;
                ctl.rd_y = sy_reg;
            end
            ST_F_RD: begin
                unique case (k_reg)
                    2'd0: begin
                        ctl.rd_x = sx_reg - pdx;
                        ctl.rd_y = sy_reg - pdy;
                    end
                    2'd1: begin
                        ctl.rd_x = sx_reg - pdx - sdx_reg;
                        ctl.rd_y = sy_reg - pdy - sdy_reg;
                    end
                    2'd2: begin
                        ctl.rd_x = sx_reg + pdx;
                        ctl.rd_y = sy_reg + pdy;
                    end
                    default: begin
                        ctl.rd_x = sx_reg + pdx - sdx_reg;
                        ctl.rd_y = sy_reg + pdy - sdy_reg;
                    end
                endcase
            end
            ST_C_RD: begin
                ctl.rd_x = (k_reg == 2'd0) ? px_reg + ddx_reg : px_reg;
                ctl.rd_y = (k_reg == 2'd0) ? py_reg : py_reg + ddy_reg;
            end
            default: begin
                ctl.rd_x = px_reg;
                ctl.rd_y = py_reg;
            end
        endcase
    end

    // end of a straight scan and its outcome
    always_comb begin
        s_end  = 1'b0;
        s_hit  = 1'b0;
        forced = (fb_reg[0] & ~fb_reg[1]) | (fb_reg[2] & ~rd_open);
        if (state_reg == ST_S_CHK) begin
            if (!rd_open) begin
                s_end = 1'b1;
            end else if (sx_reg == gx_reg && sy_reg == gy_reg) begin
                s_end = 1'b1;
                s_hit = 1'b1;
            end
        end else if (state_reg == ST_F_CHK && k_reg == 2'd3) begin
            if (forced) begin
                s_end = 1'b1;
                s_hit = 1'b1;
            end else if (sn_inc > {1'b0, (sub_reg ? sb_reg : pb_reg)}) begin
                s_end = 1'b1;
                s_hit = emit_reg && !sub_reg;
            end
        end
    end

    gjps_map u_map (
        .aclk    (aclk),
        .ctl     (ctl),
        .rd_open (rd_open)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            gw_reg    <= 9'd256;
            gh_reg    <= 9'd256;
            pb_reg    <= 16'hFFFF;
            sb_reg    <= 16'd16;
            found_reg <= 1'b0;
            jx_reg    <= '0;
            jy_reg    <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_addr)
                    gjps_pkg::CFG_GRID_WIDTH:  gw_reg <= cfg_data[8:0];
                    gjps_pkg::CFG_GRID_HEIGHT: gh_reg <= cfg_data[8:0];
                    gjps_pkg::CFG_PRIM_BUDGET: pb_reg <= cfg_data;
                    default:                   sb_reg <= cfg_data;
                endcase
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (&clr_reg) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid && s_tuser == gjps_pkg::REQ_QUERY) begin
                        gx_reg   <= gjps_pkg::CW'(s_tdata[28:21]);
                        gy_reg   <= gjps_pkg::CW'(s_tdata[36:29]);
                        emit_reg <= s_tdata[37];
                        if (in_dx == 0 && in_dy == 0) begin
                            found_reg <= 1'b0;
                            jx_reg    <= '0;
                            jy_reg    <= '0;
                            state_reg <= ST_OUT;
                        end else if (in_dx != 0 && in_dy != 0) begin
                            px_reg    <= in_x;
                            py_reg    <= in_y;
                            ddx_reg   <= in_dx;
                            ddy_reg   <= in_dy;
                            dn_reg    <= '0;
                            state_reg <= ST_D_RD;
                        end else begin
                            sx_reg    <= in_x;
                            sy_reg    <= in_y;
                            sdx_reg   <= in_dx;
                            sdy_reg   <= in_dy;
                            sn_reg    <= '0;
                            sub_reg   <= 1'b0;
                            state_reg <= ST_S_RD;
                        end
                    end
                end
                ST_S_RD: state_reg <= ST_S_CHK;
                ST_F_RD: state_reg <= ST_F_CHK;
                ST_D_RD: state_reg <= ST_D_CHK;
                ST_C_RD: state_reg <= ST_C_CHK;
                ST_S_CHK, ST_F_CHK: begin
                    if (state_reg == ST_F_CHK) begin
                        fb_reg[k_reg] <= rd_open;
                    end
                    if (s_end) begin
                        if (!sub_reg) begin
                            found_reg <= s_hit;
                            jx_reg    <= s_hit ? sx_reg[7:0] : 8'd0;
                            jy_reg    <= s_hit ? sy_reg[7:0] : 8'd0;
                            state_reg <= ST_OUT;
                        end else if (s_hit) begin
                            found_reg <= 1'b1;
                            jx_reg    <= px_reg[7:0];
                            jy_reg    <= py_reg[7:0];
                            state_reg <= ST_OUT;
                        end else if (!side_reg) begin
                            sx_reg    <= px_reg;
                            sy_reg    <= py_reg + ddy_reg;
                            sdx_reg   <= '0;
                            sdy_reg   <= ddy_reg;
                            sn_reg    <= '0;
                            side_reg  <= 1'b1;
                            state_reg <= ST_S_RD;
                        end else begin
                            k_reg     <= 2'd0;
                            state_reg <= ST_C_RD;
                        end
                    end else if (state_reg == ST_S_CHK) begin
                        k_reg     <= 2'd0;
                        state_reg <= ST_F_RD;
                    end else if (k_reg != 2'd3) begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= ST_F_RD;
                    end else begin
                        sn_reg    <= sn_inc;
                        sx_reg    <= sx_reg + sdx_reg;
                        sy_reg    <= sy_reg + sdy_reg;
                        state_reg <= ST_S_RD;
                    end
                end
                ST_D_CHK: begin
                    if (!rd_open) begin
                        found_reg <= 1'b0;
                        jx_reg    <= '0;
                        jy_reg    <= '0;
                        state_reg <= ST_OUT;
                    end else if (px_reg == gx_reg || py_reg == gy_reg) begin
                        found_reg <= 1'b1;
                        jx_reg    <= px_reg[7:0];
                        jy_reg    <= py_reg[7:0];
                        state_reg <= ST_OUT;
                    end else if (dn_inc > {1'b0, pb_reg}) begin
                        found_reg <= emit_reg;
                        jx_reg    <= emit_reg ? px_reg[7:0] : 8'd0;
                        jy_reg    <= emit_reg ? py_reg[7:0] : 8'd0;
                        state_reg <= ST_OUT;
                    end else begin
                        dn_reg    <= dn_inc;
                        sx_reg    <= px_reg + ddx_reg;
                        sy_reg    <= py_reg;
                        sdx_reg   <= ddx_reg;
                        sdy_reg   <= '0;
                        sn_reg    <= '0;
                        sub_reg   <= 1'b1;
                        side_reg  <= 1'b0;
                        state_reg <= ST_S_RD;
                    end
                end
                ST_C_CHK: begin
                    if (k_reg == 2'd0) begin
                        fb_reg[0] <= rd_open;
                        k_reg     <= 2'd1;
                        state_reg <= ST_C_RD;
                    end else if (fb_reg[0] && rd_open) begin
                        px_reg    <= px_reg + ddx_reg;
                        py_reg    <= py_reg + ddy_reg;
                        state_reg <= ST_D_RD;
                    end else begin
                        found_reg <= 1'b0;
                        jx_reg    <= '0;
                        jy_reg    <= '0;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_out_blocks_in: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken while result pending");
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == 16'd0)) else $error("miss with cell");
    a_idle_after_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> s_tready) else $error("not idle after result");
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser) |=> !s_tready) else $error("query not started");
endmodule
`default_nettype wire

// ===== verif/gjps_scan_checker.sv =====
// Scoreboard for the grid jump point scan unit: tracks map and registers, predicts and compares.
`default_nettype none
module gjps_scan_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [39:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,
    input  wire logic        m_tuser,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_data,
    output int               fail_count,
    output int               pending
);
    typedef struct packed {
        logic       found;
        logic [7:0] jx;
        logic [7:0] jy;
    } jump_res_t;

    logic      cell_open [0:gjps_pkg::MAX_WIDTH*gjps_pkg::MAX_HEIGHT-1];
    int        cols, rows, walk_limit, side_limit;
    int        gx, gy;
    jump_res_t jump_q[$];

    function automatic int step_of(input logic [1:0] v);
        case (v)
            2'd0:    return 0;
            2'd1:    return 1;
            default: return -1;
        endcase
    endfunction

    function automatic bit passable(input int x, input int y);
        int w, h;
        w = (cols < gjps_pkg::MAX_WIDTH) ? cols : gjps_pkg::MAX_WIDTH;
        h = (rows < gjps_pkg::MAX_HEIGHT) ? rows : gjps_pkg::MAX_HEIGHT;
        if (x < 0 || y < 0 || x >= w || y >= h) return 0;
        return cell_open[y*gjps_pkg::MAX_WIDTH + x];
    endfunction

    function automatic bit has_forced(input int x, input int y, input int dx, input int dy);
        if (dx != 0)
            return (passable(x, y-1) && !passable(x-dx, y-1)) ||
                   (passable(x, y+1) && !passable(x-dx, y+1));
        return (passable(x-1, y) && !passable(x-1, y-dy)) ||
               (passable(x+1, y) && !passable(x+1, y-dy));
    endfunction

    function automatic bit line_scan(input int sx, input int sy, input int dx, input int dy,
                                     input int lim, input bit emit,
                                     output int ox, output int oy);
        int x, y, n;
        x = sx; y = sy; n = 0; ox = 0; oy = 0;
        forever begin
            if (!passable(x, y)) return 0;
            if ((x == gx && y == gy) || has_forced(x, y, dx, dy)) begin
                ox = x; oy = y;
                return 1;
            end
            n++;
            if (n > lim) begin
                ox = x; oy = y;
                return emit;
            end
            x += dx; y += dy;
        end
    endfunction

    function automatic bit diag_scan(input int sx, input int sy, input int dx, input int dy,
                                     input bit emit, output int ox, output int oy);
        int x, y, n, tx, ty;
        x = sx; y = sy; n = 0; ox = 0; oy = 0;
        forever begin
            if (!passable(x, y)) return 0;
            ox = x; oy = y;
            if (x == gx || y == gy) return 1;
            n++;
            if (n > walk_limit) return emit;
            if (line_scan(x+dx, y, dx, 0, side_limit, 0, tx, ty)) return 1;
            if (line_scan(x, y+dy, 0, dy, side_limit, 0, tx, ty)) return 1;
            if (!(passable(x+dx, y) && passable(x, y+dy))) return 0;
            x += dx; y += dy;
        end
    endfunction

    function automatic jump_res_t find_jump(input logic [39:0] d);
        int dx, dy, ox, oy;
        bit hit;
        jump_res_t r;
        dx = step_of(d[18:17]);
        dy = step_of(d[20:19]);
        gx = int'(d[28:21]);
        gy = int'(d[36:29]);
        ox = 0; oy = 0;
        if (dx == 0 && dy == 0) hit = 0;
        else if (dx != 0 && dy != 0)
            hit = diag_scan(int'(d[7:0]), int'(d[15:8]), dx, dy, d[37], ox, oy);
        else
            hit = line_scan(int'(d[7:0]), int'(d[15:8]), dx, dy, walk_limit, d[37], ox, oy);
        r.found = hit;
        r.jx = hit ? ox[7:0] : 8'd0;
        r.jy = hit ? oy[7:0] : 8'd0;
        return r;
    endfunction

    initial begin
        foreach (cell_open[i]) cell_open[i] = 1'b0;
        cols = 256; rows = 256; walk_limit = 65535; side_limit = 16;
        gx = 0; gy = 0;
        fail_count = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        jump_res_t want, got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = '{m_tuser, m_tdata[7:0], m_tdata[15:8]};
                if (jump_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result word found=%0d x=%0d y=%0d",
                                 got.found, got.jx, got.jy);
                end else begin
                    want = jump_q.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: want found=%0d x=%0d y=%0d, got %0d %0d %0d",
                                     want.found, want.jx, want.jy,
                                     got.found, got.jx, got.jy);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    gjps_pkg::CFG_GRID_WIDTH:  cols = int'(cfg_data[8:0]);
                    gjps_pkg::CFG_GRID_HEIGHT: rows = int'(cfg_data[8:0]);
                    gjps_pkg::CFG_PRIM_BUDGET: walk_limit = int'(cfg_data);
                    gjps_pkg::CFG_SUB_BUDGET:  side_limit = int'(cfg_data);
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == gjps_pkg::REQ_WRITE)
                    cell_open[int'(s_tdata[15:8])*gjps_pkg::MAX_WIDTH + int'(s_tdata[7:0])]
                        = s_tdata[16];
                else
                    jump_q.insert(jump_q.size(), find_jump(s_tdata));
            end
            pending = jump_q.size();
        end
    end
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench top for the grid jump point scan unit: stimulus, stalls and verdict.
`default_nettype none
module tb_top;
    logic        aclk;
    logic        aresetn;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_addr = gjps_pkg::CFG_GRID_WIDTH;
    logic [15:0] cfg_data = '0;
    int          fail_count, pending;
    bit          calm;

    grid_jump_point_scan_unit DUT (.*);
    gjps_scan_checker u_chk (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #400_000_000;
        $display("grid_jump_point_scan_unit regression: fail");
        $finish;
    end

    function automatic int gap_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge aclk) m_tready <= (gap_len() == 0);

    task automatic send_word(input logic kind, input logic [39:0] d);
        int g;
        s_tuser  <= kind;
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic put_cell(input int x, input int y, input int w);
        send_word(gjps_pkg::REQ_WRITE,
                  {2'b0, 1'b0, 8'd0, 8'd0, 2'd0, 2'd0, w[0], y[7:0], x[7:0]});
    endtask

    task automatic ask_jump(input int x, input int y, input int dx,
                            input int dy, input int gxx, input int gyy,
                            input int emit);
        send_word(gjps_pkg::REQ_QUERY, {2'b0, emit[0], gyy[7:0], gxx[7:0], dy[1:0], dx[1:0],
                                        1'b0, y[7:0], x[7:0]});
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input int val);
        cfg_addr  <= idx;
        cfg_data  <= val[15:0];
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_all(input int w, input int h, input int pb, input int sb);
        set_reg(gjps_pkg::CFG_GRID_WIDTH, w);
        set_reg(gjps_pkg::CFG_GRID_HEIGHT, h);
        set_reg(gjps_pkg::CFG_PRIM_BUDGET, pb);
        set_reg(gjps_pkg::CFG_SUB_BUDGET, sb);
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick(input int lo, input int hi, input int a, input int b);
        case ($urandom_range(0, 3))
            0:       return a;
            1:       return b;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    initial begin
        int w, h, span_x, span_y;
        aresetn = 1'b0;
        calm = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: corridor on row 1, wall corners, far corner, zero dir, dir code 2 (steps as -1)
        for (int i = 0; i < 6; i++) put_cell(i, 1, 1);
        put_cell(3, 0, 1);
        put_cell(255, 255, 1);
        put_cell(254, 254, 1);
        put_cell(2, 1, 0);
        put_cell(2, 1, 1);
        ask_jump(0, 1, 1, 0, 200, 200, 0);
        ask_jump(5, 1, 3, 0, 0, 1, 1);
        ask_jump(0, 1, 2, 0, 9, 9, 1);
        ask_jump(254, 254, 1, 1, 0, 0, 1);
        ask_jump(255, 255, 3, 3, 0, 0, 0);
        ask_jump(0, 1, 0, 0, 0, 1, 1);
        ask_jump(0, 0, 0, 1, 0, 0, 1);
        drain();
        set_all(4, 2, 0, 0);
        ask_jump(0, 1, 1, 0, 200, 200, 1);
        ask_jump(0, 1, 1, 0, 200, 200, 0);
        ask_jump(4, 1, 3, 0, 0, 0, 1);
        ask_jump(1, 1, 1, 2, 9, 9, 1);
        drain();
        set_all(256, 256, 65535, 65535);
        ask_jump(0, 1, 1, 1, 255, 255, 1);
        ask_jump(0, 1, 1, 0, 255, 255, 1);
        calm = 1'b1;
        ask_jump(1, 1, 3, 0, 255, 255, 0);
        calm = 1'b0;
        drain();

        // random phases: map a small region, then walk it
        for (int ph = 0; ph < 14; ph++) begin
            calm = (ph % 5 == 3);
            w = pick(2, 16, 1, 256);
            h = pick(2, 16, 1, 256);
            set_all(w, h, pick(1, 40, 0, 65535), pick(1, 20, 0, 65535));
            span_x = (w < 16) ? w : 16;
            span_y = (h < 16) ? h : 16;
            for (int i = 0; i < 50; i++) begin
                if ($urandom_range(0, 19) == 0)
                    put_cell($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1));
                else
                    put_cell($urandom_range(0, span_x), $urandom_range(0, span_y),
                             int'($urandom_range(0, 9) < 7));
            end
            for (int i = 0; i < 45; i++) begin
                if ($urandom_range(0, 9) == 0)
                    ask_jump($urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 3), $urandom_range(0, 3),
                             $urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 1));
                else
                    ask_jump($urandom_range(0, span_x - 1), $urandom_range(0, span_y - 1),
                             $urandom_range(0, 3), $urandom_range(0, 3),
                             $urandom_range(0, span_x), $urandom_range(0, span_y),
                             $urandom_range(0, 1));
            end
            drain();
        end

        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("grid_jump_point_scan_unit regression: pass");
        else
            $display("grid_jump_point_scan_unit regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

// ===== grid_jump_point_scan_unit.f =====
design/gjps_pkg.sv
design/gjps_map.sv
design/grid_jump_point_scan_unit.sv
verif/gjps_scan_checker.sv
verif/tb_top.sv
